// ----- rtl/core/ccpe_pkg.sv -----
// shared widths, constants and payload types of the cubic curve point evaluator
`timescale 1ns / 1ps
package ccpe_pkg;

  // number of steps along the curve is a power of two
  localparam int STEPS_LOG2 = 6;
  localparam int STEPS      = 1 << STEPS_LOG2;
  localparam int CUBE_LOG2  = 3 * STEPS_LOG2;
  localparam int CUBE       = 1 << CUBE_LOG2;

  localparam int COORD_W = 16;
  localparam int STEP_W  = 10;
  localparam int OUT_W   = 18;
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // point index j = 1..STEPS and its complement b = STEPS - j
  localparam int JW  = STEPS_LOG2 + 1;
  localparam int BW  = STEPS_LOG2;
  localparam int JJW = 2 * BW + 1;
  localparam int BBW = 2 * BW;
  localparam int KW  = BW + 2;
  localparam int H2W = JJW + KW;
  localparam int H3W = JW + BBW;
  localparam int H4W = JJW + BW;
  // basis weights never exceed STEPS^3
  localparam int HW  = CUBE_LOG2 + 1;

  localparam int DW  = COORD_W + 1;
  localparam int TW  = COORD_W + 3;
  localparam int PW  = TW + HW + 1;
  localparam int SW  = PW + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] s;
    logic signed [DW-1:0]      d;
    logic signed [TW-1:0]      t1;
    logic signed [TW-1:0]      t2;
  } coord_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] s;
    logic signed [PW-1:0]      m2;
    logic signed [PW-1:0]      m3;
    logic signed [PW-1:0]      m4;
  } prod_t;

  typedef struct packed {
    logic signed [SW-1:0] sa;
    logic signed [SW-1:0] sb;
  } part_t;

endpackage

// ----- rtl/core/ccpe_ifs.sv -----
// request, response and configuration channels of the cubic curve point evaluator
`timescale 1ns / 1ps
interface ccpe_req_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ccpe_pkg::COORD_W-1:0]  start_x;
  logic signed [ccpe_pkg::COORD_W-1:0]  start_y;
  logic signed [ccpe_pkg::COORD_W-1:0]  end_x;
  logic signed [ccpe_pkg::COORD_W-1:0]  end_y;
  logic signed [ccpe_pkg::COORD_W-1:0]  ctrl1_x;
  logic signed [ccpe_pkg::COORD_W-1:0]  ctrl1_y;
  logic signed [ccpe_pkg::COORD_W-1:0]  ctrl2_x;
  logic signed [ccpe_pkg::COORD_W-1:0]  ctrl2_y;
  logic        [ccpe_pkg::STEP_W-1:0]   step;

  modport source (output valid, start_x, start_y, end_x, end_y, ctrl1_x, ctrl1_y,
                  ctrl2_x, ctrl2_y, step, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, ctrl1_x, ctrl1_y,
                ctrl2_x, ctrl2_y, step, output ready);
endinterface

interface ccpe_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [ccpe_pkg::OUT_W-1:0]  point_x;
  logic signed [ccpe_pkg::OUT_W-1:0]  point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink (input valid, point_x, point_y, output ready);
endinterface

interface ccpe_cfg_if;
  logic valid;
  logic ready;
  logic curve_form;

  modport source (output valid, curve_form, input ready);
  modport sink (input valid, curve_form, output ready);
endinterface

// ----- rtl/core/cubic_curve_point_evaluator.sv -----
// cubic curve point evaluator: six-stage pipeline from request to curve point
//
// Each request on req carries start point, end point, two control values and a
// step index; rsp returns one point (point_x, point_y) per request, in order.
// cfg writes curve_form: 1 treats the controls as Bezier control points, 0 as
// Hermite tangents. Write it only while no request is in flight.
// The accepting edge loads the first of six register stages, and rsp.valid
// is driven by the last. One request is taken per cycle while req.ready is
// high; the depth is set by the weight multipliers (j^2, then the cubic
// weights), the coordinate-by-weight multipliers, and two adder stages.
// Each stage holds its item while the next one is full, so bubbles close up
// under back-pressure; req.ready drops only when all six stages are full and
// rsp.ready is low. Nothing is lost or repeated across a stall.
// Reset empties the pipeline and sets curve_form to 1 (Bezier).
// Division by STEPS^3 truncates toward zero; points saturate to 18 bits.
`timescale 1ns / 1ps
module cubic_curve_point_evaluator (
  input  logic        clk,
  input  logic        rst,
  ccpe_req_if.sink    req,
  ccpe_rsp_if.source  rsp,
  ccpe_cfg_if.sink    cfg
);

  localparam logic signed [ccpe_pkg::SW-1:0] Q_MAX = ccpe_pkg::SW'(ccpe_pkg::OUT_MAX);
  localparam logic signed [ccpe_pkg::SW-1:0] Q_MIN = ccpe_pkg::SW'(ccpe_pkg::OUT_MIN);
  localparam logic signed [ccpe_pkg::SW-1:0] BIAS  = ccpe_pkg::SW'(ccpe_pkg::CUBE - 1);

  logic curve_form;

  // stage valids and ready chain
  logic v0, v1, v2, v3, v4, v5;
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage 0: index and tangents
  logic [ccpe_pkg::JW-1:0]  j0;
  logic [ccpe_pkg::BW-1:0]  b0;
  ccpe_pkg::coord_t         c0 [2];
  // stage 1: squares
  logic [ccpe_pkg::JW-1:0]  j1;
  logic [ccpe_pkg::BW-1:0]  b1;
  logic [ccpe_pkg::JJW-1:0] jj1;
  logic [ccpe_pkg::BBW-1:0] bb1;
  ccpe_pkg::coord_t         c1 [2];
  // stage 2: weights
  logic [ccpe_pkg::HW-1:0]  h2, h3, h4;
  ccpe_pkg::coord_t         c2 [2];
  // stage 3: products, stage 4: partial sums
  ccpe_pkg::prod_t          p3 [2];
  ccpe_pkg::part_t          s4 [2];
  // stage 5: output
  logic signed [ccpe_pkg::OUT_W-1:0] pt5 [2];

  // combinational next values
  logic [ccpe_pkg::STEP_W:0] step_ext;
  logic [ccpe_pkg::JW-1:0]   j_next;
  logic [ccpe_pkg::JW-1:0]   b_full;
  ccpe_pkg::coord_t          c_next [2];
  logic [ccpe_pkg::KW-1:0]   k1;
  logic [ccpe_pkg::H2W-1:0]  h2_w;
  logic [ccpe_pkg::H3W-1:0]  h3_w;
  logic [ccpe_pkg::H4W-1:0]  h4_w;
  logic signed [ccpe_pkg::SW-1:0] sum5 [2];
  logic signed [ccpe_pkg::SW-1:0] q5 [2];
  logic signed [ccpe_pkg::OUT_W-1:0] pt_next [2];

  function automatic ccpe_pkg::coord_t make_coord(
    input logic                                sel_bez,
    input logic signed [ccpe_pkg::COORD_W-1:0] s,
    input logic signed [ccpe_pkg::COORD_W-1:0] e,
    input logic signed [ccpe_pkg::COORD_W-1:0] ca,
    input logic signed [ccpe_pkg::COORD_W-1:0] cb
  );
    ccpe_pkg::coord_t              c;
    logic signed [ccpe_pkg::DW-1:0] da, db;
    logic signed [ccpe_pkg::TW-1:0] ta, tb;
    da = ccpe_pkg::DW'(ca) - ccpe_pkg::DW'(s);
    db = ccpe_pkg::DW'(e) - ccpe_pkg::DW'(cb);
    ta = ccpe_pkg::TW'(da);
    tb = ccpe_pkg::TW'(db);
    c.s = s;
    c.d = ccpe_pkg::DW'(e) - ccpe_pkg::DW'(s);
    if (sel_bez) begin
      c.t1 = (ta <<< 1) + ta;
      c.t2 = (tb <<< 1) + tb;
    end else begin
      c.t1 = ccpe_pkg::TW'(ca);
      c.t2 = ccpe_pkg::TW'(cb);
    end
    return c;
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_form <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      curve_form <= cfg.curve_form;
    end
  end

  assign rdy5      = !v5 || rsp.ready;
  assign rdy4      = !v4 || rdy5;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign rdy0      = !v0 || rdy1;
  assign req.ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy0) v0 <= req.valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 0: j = min(step + 1, STEPS), tangents per curve form
  always_comb begin
    step_ext = {1'b0, req.step};
    if (step_ext >= (ccpe_pkg::STEP_W + 1)'(ccpe_pkg::STEPS)) begin
      j_next = ccpe_pkg::JW'(ccpe_pkg::STEPS);
    end else begin
      j_next = ccpe_pkg::JW'(step_ext + 1'b1);
    end
    b_full    = ccpe_pkg::JW'(ccpe_pkg::STEPS) - j_next;
    c_next[0] = make_coord(curve_form, req.start_x, req.end_x, req.ctrl1_x, req.ctrl2_x);
    c_next[1] = make_coord(curve_form, req.start_y, req.end_y, req.ctrl1_y, req.ctrl2_y);
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      j0 <= j_next;
      b0 <= b_full[ccpe_pkg::BW-1:0];
      c0 <= c_next;
    end
  end

  // stage 1: j^2 and (STEPS - j)^2
  always_ff @(posedge clk) begin
    if (rdy1) begin
      j1  <= j0;
      b1  <= b0;
      jj1 <= ccpe_pkg::JJW'(j0) * ccpe_pkg::JJW'(j0);
      bb1 <= ccpe_pkg::BBW'(b0) * ccpe_pkg::BBW'(b0);
      c1  <= c0;
    end
  end

  // stage 2: h2 = j^2 (STEPS + 2b), h3 = j b^2, -h4 = j^2 b
  always_comb begin
    k1   = ccpe_pkg::KW'(ccpe_pkg::STEPS) + ccpe_pkg::KW'({b1, 1'b0});
    h2_w = ccpe_pkg::H2W'(jj1) * ccpe_pkg::H2W'(k1);
    h3_w = ccpe_pkg::H3W'(j1) * ccpe_pkg::H3W'(bb1);
    h4_w = ccpe_pkg::H4W'(jj1) * ccpe_pkg::H4W'(b1);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      h2 <= h2_w[ccpe_pkg::HW-1:0];
      h3 <= h3_w[ccpe_pkg::HW-1:0];
      h4 <= h4_w[ccpe_pkg::HW-1:0];
      c2 <= c1;
    end
  end

  // stage 3: h1 = STEPS^3 - h2, so start*h1 + end*h2 = start*STEPS^3 + (end-start)*h2
  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int i = 0; i < 2; i++) begin
        p3[i].s  <= c2[i].s;
        p3[i].m2 <= ccpe_pkg::PW'(c2[i].d) * ccpe_pkg::PW'($signed({1'b0, h2}));
        p3[i].m3 <= ccpe_pkg::PW'(c2[i].t1) * ccpe_pkg::PW'($signed({1'b0, h3}));
        p3[i].m4 <= ccpe_pkg::PW'(c2[i].t2) * ccpe_pkg::PW'($signed({1'b0, h4}));
      end
    end
  end

  // stage 4: partial sums
  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int i = 0; i < 2; i++) begin
        s4[i].sa <= (ccpe_pkg::SW'(p3[i].s) <<< ccpe_pkg::CUBE_LOG2) + ccpe_pkg::SW'(p3[i].m2);
        s4[i].sb <= ccpe_pkg::SW'(p3[i].m3) - ccpe_pkg::SW'(p3[i].m4);
      end
    end
  end

  // stage 5: total, divide toward zero, saturate
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sum5[i] = s4[i].sa + s4[i].sb;
      if (sum5[i] < 0) begin
        q5[i] = (sum5[i] + BIAS) >>> ccpe_pkg::CUBE_LOG2;
      end else begin
        q5[i] = sum5[i] >>> ccpe_pkg::CUBE_LOG2;
      end
      if (q5[i] > Q_MAX) begin
        pt_next[i] = ccpe_pkg::OUT_W'(Q_MAX);
      end else if (q5[i] < Q_MIN) begin
        pt_next[i] = ccpe_pkg::OUT_W'(Q_MIN);
      end else begin
        pt_next[i] = $signed(q5[i][ccpe_pkg::OUT_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      pt5 <= pt_next;
    end
  end

  assign rsp.valid   = v5;
  assign rsp.point_x = pt5[0];
  assign rsp.point_y = pt5[1];

  // an accepted request always lands with a point index in 1..STEPS
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (v0 && j0 >= 1 && j0 <= ccpe_pkg::JW'(ccpe_pkg::STEPS)))
    else $error("point index out of range");

  // the blend weight for the end point never exceeds STEPS^3
  a_weight_bound: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (h2 <= ccpe_pkg::HW'(ccpe_pkg::CUBE)))
    else $error("end point weight above STEPS^3");

  // input back-pressure only when every stage is occupied and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (v0 && v1 && v2 && v3 && v4 && v5 && !rsp.ready))
    else $error("request stalled with a bubble in the pipeline");

  // a stalled stage-4 item behind a stalled output keeps its partial sums
  a_hold_s4: assert property (@(posedge clk) disable iff (rst)
    (v5 && !rsp.ready && v4) |=> (v4 && $stable(s4[0]) && $stable(s4[1])))
    else $error("stage 4 changed under stall");

endmodule
